@@ hw/rtl/sdhnp_pkg.sv @@
// Package with character codes, parser phase codes and digit helpers for the number parser.
package sdhnp_pkg;

  localparam int unsigned AccW  = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned CntW  = 8;
  localparam int unsigned PhW   = 3;
  localparam int unsigned OutDataW = 48;

  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharDollar = 8'h24;

  localparam logic [PhW-1:0] PhSign   = 3'd0;
  localparam logic [PhW-1:0] PhPrefix = 3'd1;
  localparam logic [PhW-1:0] PhDec    = 3'd2;
  localparam logic [PhW-1:0] PhHex    = 3'd3;
  localparam logic [PhW-1:0] PhSkip   = 3'd4;

  typedef struct packed {
    logic [AccW-1:0] value;
    logic            ok;
  } signed_val_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } digit_t;

  // Negates a nonzero magnitude when negative, and checks that the sign bit agrees.
  function automatic signed_val_t apply_sign(input logic [AccW-1:0] acc, input logic neg);
    signed_val_t r;
    r.value = acc;
    r.ok    = 1'b1;
    if (acc != '0) begin
      if (neg) begin
        r.value = '0 - acc;
      end
      r.ok = (r.value[AccW-1] == neg);
    end
    return r;
  endfunction

  function automatic digit_t dec_digit(input logic [CharW-1:0] c);
    digit_t r;
    r.valid = (c >= 8'h30) && (c <= 8'h39);
    r.digit = c[3:0];
    return r;
  endfunction

  // Hex digits of either case; letters map to 10..15.
  function automatic digit_t hex_digit(input logic [CharW-1:0] c);
    digit_t r;
    r.valid = 1'b0;
    r.digit = c[3:0];
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r.valid = 1'b1;
    end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
      r.valid = 1'b1;
      r.digit = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/signed_decimal_hex_number_parser.sv @@
// Streaming parser for signed decimal or dollar-prefixed hexadecimal 32-bit integers.
// An accepted character waits in the input register until it is processed, and a string's
// result is loaded into the output register when its last character is processed.
// Throughput: one character per cycle; the input stalls only when a finished result
// still waits in the output register while the next string end is ready to be processed.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to the
// start of a string; the parser also returns there by itself after every result.
module signed_decimal_hex_number_parser
  import sdhnp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] char_code
  input  logic                s_axis_tlast,   // last character of the string
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [31:0] value, [32] ok, [40:33] remaining,
                                              // [47:41] zero
);

  // Input register: holds one accepted transaction until it is processed.
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;

  // Parser state.
  logic [PhW-1:0]  phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [AccW-1:0] accum_q, accum_d;
  logic            good_q, good_d;
  logic [CntW-1:0] left_q, left_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic out_free;
  logic advance;
  logic out_load;

  // A character without the last flag never needs the output register, so it moves on
  // even while a result is stalled downstream.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!last_q || out_free);
  assign out_load      = advance && last_q;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    char_d     = char_q;
    last_d     = last_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      char_d     = s_axis_tdata;
      last_d     = s_axis_tlast;
    end
  end

  // Per-character step. The phases are walked in order combinationally: a character
  // that is neither a sign nor a dollar falls through into the digit phase at once.
  logic [PhW-1:0]  ph;
  logic            neg;
  logic [AccW-1:0] acc;
  logic            gd;
  logic [CntW-1:0] lc;
  logic            done;
  logic [AccW-1:0] res_value;
  logic            res_ok;
  logic [CntW-1:0] res_rem;
  digit_t          dd;
  digit_t          hd;
  signed_val_t     sv_stop;
  signed_val_t     sv_end;

  always_comb begin
    ph        = phase_q;
    neg       = neg_q;
    acc       = accum_q;
    gd        = good_q;
    lc        = left_q;
    done      = 1'b0;
    res_value = '0;
    res_ok    = 1'b0;
    res_rem   = '0;
    dd        = dec_digit(char_q);
    hd        = hex_digit(char_q);
    sv_stop   = apply_sign(accum_q, neg_q);

    if (ph == PhSign) begin
      ph = PhPrefix;
      if ((char_q == CharPlus) || (char_q == CharMinus)) begin
        neg  = (char_q == CharMinus);
        done = 1'b1;
      end
    end

    if (!done && (ph == PhPrefix)) begin
      if (char_q == CharDollar) begin
        ph   = PhHex;
        done = 1'b1;
      end else begin
        ph = PhDec;
      end
    end

    if (!done) begin
      unique case (ph)
        PhDec: begin
          if (dd.valid) begin
            if (acc[AccW-1:AccW-4] != 4'd0) begin
              gd = 1'b0;
              lc = CntW'(1);
              ph = PhSkip;
            end else begin
              // Times ten as 8x + 2x, wrapping at 32 bits.
              acc = {acc[AccW-4:0], 3'b000} + {acc[AccW-2:0], 1'b0}
                    + {{(AccW-4){1'b0}}, dd.digit};
            end
          end else begin
            acc = sv_stop.value;
            gd  = sv_stop.ok;
            lc  = CntW'(1);
            ph  = PhSkip;
          end
        end
        PhHex: begin
          if (!hd.valid) begin
            acc = sv_stop.value;
            gd  = sv_stop.ok;
            lc  = CntW'(1);
            ph  = PhSkip;
          end else begin
            // Shift one bit at a time, at most four, stopping once the top bit is set.
            priority if (acc[AccW-1]) begin
              gd = 1'b0;
            end else if (acc[AccW-2]) begin
              acc = {acc[AccW-2:0], 1'b0};
              gd  = 1'b0;
            end else if (acc[AccW-3]) begin
              acc = {acc[AccW-3:0], 2'b00};
              gd  = 1'b0;
            end else if (acc[AccW-4]) begin
              acc = {acc[AccW-4:0], 3'b000};
              gd  = 1'b0;
            end else begin
              acc = {acc[AccW-5:0], hd.digit};
            end
            if (!gd) begin
              lc = CntW'(1);
              ph = PhSkip;
            end
          end
        end
        default: begin
          if (lc != {CntW{1'b1}}) begin
            lc = lc + CntW'(1);
          end
        end
      endcase
    end

    sv_end = apply_sign(acc, neg);

    if (done) begin
      // A sign or dollar that ends the string fails with zero.
      res_value = '0;
      res_ok    = 1'b0;
      res_rem   = '0;
    end else if (ph == PhDec) begin
      res_value = sv_end.value;
      res_ok    = sv_end.ok;
    end else if (ph == PhHex) begin
      // Ending on a hex digit applies the sign without the sign check.
      res_value = neg ? ('0 - acc) : acc;
      res_ok    = 1'b1;
    end else begin
      res_value = acc;
      res_ok    = gd;
      res_rem   = lc;
    end

    phase_d = phase_q;
    neg_d   = neg_q;
    accum_d = accum_q;
    good_d  = good_q;
    left_d  = left_q;
    if (advance) begin
      if (last_q) begin
        phase_d = PhSign;
        neg_d   = 1'b0;
        accum_d = '0;
        good_d  = 1'b1;
        left_d  = '0;
      end else begin
        phase_d = ph;
        neg_d   = neg;
        accum_d = acc;
        good_d  = gd;
        left_d  = lc;
      end
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(OutDataW - AccW - 1 - CntW){1'b0}}, res_rem, res_ok, res_value};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhSign;
      neg_q       <= 1'b0;
      accum_q     <= '0;
      good_q      <= 1'b1;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      good_q      <= good_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // After every result the parser is back at the start of a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (phase_q == PhSign) && (accum_q == '0) && good_q && (left_q == '0))
    else $error("parser state not cleared after a result");

  // The skip count only runs once parsing has stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != '0) |-> (phase_q == PhSkip))
    else $error("skip count nonzero outside the skip phase");

  // Failure is only recorded when parsing stops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDec || phase_q == PhHex || phase_q == PhPrefix) |-> good_q)
    else $error("failure flag set while still parsing digits");

  // A held character is not replaced before it has been processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(char_q) && $stable(last_q))
    else $error("pending input character lost");

endmodule

@@ bench/signed_decimal_hex_number_parser_chk.sv @@
`timescale 1ns / 1ps
// Scoreboard that predicts parser results from accepted characters and checks the result stream.
module signed_decimal_hex_number_parser_chk
  import sdhnp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct {
    logic [AccW-1:0] value;
    logic            ok;
    logic [CntW-1:0] remaining;
  } parse_result_t;

  parse_result_t   expected_q[$];

  // Shadow copy of the parser state.
  logic [PhW-1:0]  ph;
  logic            neg;
  logic [AccW-1:0] acc;
  logic            good;
  logic [CntW-1:0] skipped;

  int errors       = 0;
  int results_seen = 0;

  task automatic clear_parser();
    ph      = PhSign;
    neg     = 1'b0;
    acc     = '0;
    good    = 1'b1;
    skipped = '0;
  endtask

  task automatic push_result(input logic [AccW-1:0] v, input logic k, input logic [CntW-1:0] r);
    parse_result_t e;
    e.value     = v;
    e.ok        = k;
    e.remaining = r;
    expected_q.push_back(e);
  endtask

  // Applies the sign to a nonzero magnitude and tells whether the sign bit agrees with it.
  task automatic settle_sign(output logic ok_o);
    ok_o = 1'b1;
    if (acc != '0) begin
      if (neg) begin
        acc = -acc;
      end
      ok_o = (acc[AccW-1] == neg);
    end
  endtask

  function automatic int nibble_of(input logic [CharW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  task automatic stop_parsing(input logic g);
    good    = g;
    skipped = 8'd1;
    ph      = PhSkip;
  endtask

  task automatic parse_char(input logic [CharW-1:0] c, input logic lst);
    logic g;
    logic over;
    int   nib;
    if (ph == PhSign) begin
      ph = PhPrefix;
      if (c == CharPlus || c == CharMinus) begin
        neg = (c == CharMinus);
        if (lst) begin
          push_result('0, 1'b0, '0);
          clear_parser();
        end
        return;
      end
    end
    if (ph == PhPrefix) begin
      if (c == CharDollar) begin
        ph = PhHex;
        if (lst) begin
          push_result('0, 1'b0, '0);
          clear_parser();
        end
        return;
      end
      ph = PhDec;
    end
    case (ph)
      PhDec: begin
        if (c >= 8'h30 && c <= 8'h39) begin
          if (acc[AccW-1:28] != '0) begin
            stop_parsing(1'b0);
          end else begin
            acc = acc * 10 + AccW'(c - 8'h30);
          end
        end else begin
          settle_sign(g);
          stop_parsing(g);
        end
      end
      PhHex: begin
        nib = nibble_of(c);
        if (nib < 0) begin
          settle_sign(g);
          stop_parsing(g);
        end else begin
          // Shift in four bits one at a time, giving up once the top bit is occupied.
          over = 1'b0;
          for (int i = 0; i < 4; i++) begin
            if (acc[AccW-1]) begin
              over = 1'b1;
              break;
            end
            acc = acc << 1;
          end
          if (over) begin
            stop_parsing(1'b0);
          end else begin
            acc = acc + AccW'(nib);
          end
        end
      end
      default: begin
        if (skipped != 8'hFF) begin
          skipped = skipped + 8'd1;
        end
      end
    endcase
    if (!lst) return;
    case (ph)
      PhDec: begin
        settle_sign(g);
        push_result(acc, g, '0);
      end
      PhHex: push_result(neg ? -acc : acc, 1'b1, '0);
      default: push_result(acc, good, skipped);
    endcase
    clear_parser();
  endtask

  task automatic note_mismatch(input string what, input logic [AccW-1:0] exp_v,
                               input logic [AccW-1:0] act_v);
    errors++;
    if (errors <= 10) begin
      $display("result %0d: %s mismatch, expected %h, got %h", results_seen, what, exp_v, act_v);
    end
  endtask

  task automatic check_result(input logic [OutDataW-1:0] data);
    parse_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      note_mismatch("unexpected transaction", '0, data[31:0]);
      return;
    end
    e = expected_q.pop_front();
    if (data[31:0] != e.value) note_mismatch("value", e.value, data[31:0]);
    if (data[32] != e.ok) note_mismatch("ok", AccW'(e.ok), AccW'(data[32]));
    if (data[40:33] != e.remaining) note_mismatch("remaining", AccW'(e.remaining), AccW'(data[40:33]));
    if (data[47:41] != '0) note_mismatch("padding", '0, AccW'(data[47:41]));
  endtask

  initial clear_parser();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
    mismatches_o <= errors;
    pending_o    <= expected_q.size();
  end

endmodule

@@ bench/signed_decimal_hex_number_parser_tb.sv @@
`timescale 1ns / 1ps
// Top of the number parser testbench: clock, reset, character stimulus, result sink and verdict.
module signed_decimal_hex_number_parser_tb
  import sdhnp_pkg::*;
();

  localparam int ItemTarget    = 1850;
  localparam int LimitCycles   = 400000;
  localparam int HoldOffCycles = 600;
  localparam int SettleCycles  = 10;

  typedef logic [CharW-1:0] char_q_t[$];

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int mismatch_count;
  int pending_count;
  int cycle_count   = 0;
  int items_sent    = 0;
  int results_taken = 0;
  bit tx_nogap      = 1'b0;
  bit rx_nostall    = 1'b0;

  signed_decimal_hex_number_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The scoreboard watches both channels on its own and reports what it found.
  signed_decimal_hex_number_parser_chk u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatch_count),
    .pending_o     (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset is held low at the start and never asserted again.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    while (cycle_count < LimitCycles) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Offers one character and holds it until the parser takes it. The gap before it is
  // random unless the sender is in a back-to-back stretch.
  task automatic send_char(input logic [CharW-1:0] c, input logic lst);
    int gap;
    gap = tx_nogap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Sends a whole string; the final character carries tlast.
  task automatic send_chars(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
    if ($urandom_range(0, 7) == 0) tx_nogap = !tx_nogap;
  endtask

  task automatic send_text(input string s);
    char_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    send_chars(q);
  endtask

  // Decimal digit text: full-range values, small ones, values around the sign and
  // overflow boundaries, and runs long enough to overflow the accumulator.
  function automatic string dec_digits();
    string       s;
    int unsigned v;
    s = "";
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'd2147483647;
          1: v = 32'd2147483648;
          2: v = 32'd268435455;
          3: v = 32'd268435456;
          default: v = 32'd4294967295;
        endcase
      end
      3: begin
        repeat ($urandom_range(10, 13)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return $sformatf("%0d", v);
  endfunction

  // Hex digit text in mixed case; some runs are longer than eight digits so the
  // accumulator runs out of room.
  function automatic string hex_digits();
    string s;
    s = "";
    case ($urandom_range(0, 3))
      0: s = $sformatf("%0h", $urandom);
      1: s = $sformatf("%0h", $urandom >> $urandom_range(0, 31));
      2: repeat ($urandom_range(9, 11)) s = $sformatf("%s%0h", s, $urandom_range(0, 15));
      default: s = $sformatf("%0h", $urandom_range(0, 255));
    endcase
    foreach (s[i]) begin
      if (s[i] >= 8'h61 && s[i] <= 8'h66 && $urandom_range(0, 1) == 1) s[i] = s[i] - 8'h20;
    end
    return s;
  endfunction

  // Builds one random string. Most are well formed numbers with random content, some
  // are raw noise and some are cut short after the sign or the dollar prefix. A
  // nonzero junk_len appends a stop character and that many random bytes.
  function automatic char_q_t random_string(input int junk_len);
    char_q_t q;
    string   s;
    int      kind;
    kind = $urandom_range(0, 99);
    s    = "";
    case ($urandom_range(0, 2))
      1: q.push_back(CharPlus);
      2: q.push_back(CharMinus);
      default: ;
    endcase
    if (kind < 40 || kind >= 95) begin
      s = dec_digits();
    end else if (kind < 70) begin
      q.push_back(CharDollar);
      s = hex_digits();
    end else if (kind < 85) begin
      q.delete();
      repeat ($urandom_range(1, 6)) q.push_back(CharW'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        1: q.push_back(CharDollar);
        2: begin
          q.push_back(CharDollar);
          q.push_back(CharW'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      if (q.size() == 0) q.push_back(CharMinus);
    end
    foreach (s[i]) q.push_back(s[i]);
    if (kind < 70 && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) q.push_back(CharW'($urandom_range(0, 255)));
    end else if (kind >= 95) begin
      repeat ($urandom_range(5, 20)) q.push_back(CharW'($urandom_range(0, 255)));
    end
    if (junk_len > 0) begin
      q.push_back(8'h7A);
      repeat (junk_len) q.push_back(CharW'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // Sender: directed strings first, then random strings until the item budget is used.
  initial begin
    char_q_t q;
    int      strings_sent;
    strings_sent = 0;
    wait (rst_ni);
    @(posedge clk_i);

    // Sign alone, dollar alone and sign plus dollar each end the string too early.
    send_text("-");
    send_text("$");
    send_text("+$");
    send_text("-$");
    // No digits at all.
    send_text("x");
    // Plain decimal and hex endings, hex letters of both cases.
    send_text("-5");
    send_text("+0");
    send_text("$fF");
    send_text("$G");
    // Hex stopped by a non-digit with a negative sign.
    send_text("-$a;");
    // Both extremes of the character code.
    q = {8'hFF, 8'h00};
    send_chars(q);

    while (items_sent < ItemTarget) begin
      // Two strings carry long tails so the remaining count saturates.
      if (strings_sent == 40 || strings_sent == 120) begin
        q = random_string($urandom_range(260, 300));
      end else begin
        q = random_string(0);
      end
      send_chars(q);
      strings_sent++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every predicted result, then let the pipeline settle.
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result sink with random stalls per transaction, stretches without stalls, and one
  // long hold-off so that both parser registers fill and the input side backs up.
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      stall = rx_nostall ? 0 : $urandom_range(0, 13);
      if (results_taken == 60 && !held) begin
        stall = HoldOffCycles;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_taken++;
      if ($urandom_range(0, 9) == 0) rx_nostall = !rx_nostall;
    end
  end

endmodule
